// File: design/stereo_one_pole_equalizer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the stereo one-pole equalizer
// Same-cycle and next-cycle property checks, reset-qualified.
// ---------------------------------------------------------------------------
`ifndef STEREO_ONE_POLE_EQUALIZER_ASSERT_SVH
`define STEREO_ONE_POLE_EQUALIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOPE_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SOPE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sope_pkg.sv
// ---------------------------------------------------------------------------
// Stereo one-pole equalizer package
// Types, register codes, reset values and the mode decode tables.
// ---------------------------------------------------------------------------
package sope_pkg;

    // Default parameter values.
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ACC_BITS_DEF    = 24;
    localparam int COEF_BITS_DEF   = 16;

    // Gains are unsigned Q3.13 in 16 bits.
    localparam int GAIN_BITS = 16;
    localparam int GAIN_FRAC = 13;
    localparam int MODE_BITS = 3;

    // Configuration port geometry: eight 32-bit registers.
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_IDX_BITS  = 3;

    // Reset values; the coefficient resets are given at 16 fractional bits.
    localparam int RESET_COEF_BITS     = 16;
    localparam int COEF_LOW_POLE_RESET = 1672;
    localparam int COEF_HIGH_POLE_RST  = 22524;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd8192;
    localparam logic [GAIN_BITS-1:0] PAN_RESET  = 16'd5793;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PASS,
        MODE_LOWPASS,
        MODE_HIGHPASS,
        MODE_PAN,
        MODE_BASS,
        MODE_TREBLE,
        MODE_MID,
        MODE_EQ
    } mode_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FILTER_MODE,
        REG_COEF_LOW,
        REG_COEF_HIGH,
        REG_GAIN_BASS,
        REG_GAIN_MIDDLE,
        REG_GAIN_TREBLE,
        REG_PAN_LEFT,
        REG_PAN_RIGHT
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOW_PREP,
        ST_LOW_MUL,
        ST_LOW_UPD,
        ST_HIGH_PREP,
        ST_HIGH_MUL,
        ST_HIGH_UPD,
        ST_BASE,
        ST_TERM_PREP,
        ST_TERM_MUL,
        ST_RESULT
    } state_t;

    // Multiplicand choice: input, first accumulator, a band difference or zero.
    typedef enum logic [2:0] {
        OPD_ZERO,
        OPD_X,
        OPD_LOW,
        OPD_X_LOW,
        OPD_HIGH_LOW,
        OPD_X_HIGH
    } opd_t;

    // Multiplier choice: a gain as is, or a gain less unity.
    typedef enum logic [2:0] {
        GSEL_PAN,
        GSEL_BASS,
        GSEL_MIDDLE,
        GSEL_TREBLE,
        GSEL_BASS_M1,
        GSEL_MIDDLE_M1,
        GSEL_TREBLE_M1
    } gsel_t;

    typedef struct packed {
        opd_t  opd;
        gsel_t gsel;
    } term_t;

    // Number of gain products a mode adds to its base value.
    function automatic logic [1:0] term_count(mode_t mode);
        logic [1:0] n;
        unique case (mode) inside
            MODE_PAN, MODE_BASS, MODE_TREBLE, MODE_MID: n = 2'd1;
            MODE_EQ:                                    n = 2'd3;
            default:                                    n = 2'd0;
        endcase
        return n;
    endfunction

    // Value that enters the output sum at unity gain.
    function automatic opd_t base_sel(mode_t mode);
        opd_t o;
        unique case (mode) inside
            MODE_LOWPASS, MODE_PAN: o = OPD_LOW;
            MODE_HIGHPASS:          o = OPD_X_LOW;
            MODE_EQ:                o = OPD_ZERO;
            default:                o = OPD_X;
        endcase
        return o;
    endfunction

    // Operand and gain of each product term.
    function automatic term_t term_sel(mode_t mode, logic [1:0] idx);
        term_t t;
        unique case (mode)
            MODE_PAN:    t = '{OPD_X_LOW, GSEL_PAN};
            MODE_BASS:   t = '{OPD_LOW, GSEL_BASS_M1};
            MODE_TREBLE: t = '{OPD_X_LOW, GSEL_TREBLE_M1};
            MODE_MID:    t = '{OPD_HIGH_LOW, GSEL_MIDDLE_M1};
            MODE_EQ: begin
                case (idx)
                    2'd0:    t = '{OPD_LOW, GSEL_BASS};
                    2'd1:    t = '{OPD_HIGH_LOW, GSEL_MIDDLE};
                    default: t = '{OPD_X_HIGH, GSEL_TREBLE};
                endcase
            end
            default:     t = '{OPD_ZERO, GSEL_BASS};
        endcase
        return t;
    endfunction

endpackage

// File: design/stereo_one_pole_equalizer.sv
// ---------------------------------------------------------------------------
// Stereo one-pole equalizer
// Two-lane bit-serial filter and gain engine for stereo sample pairs.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ stream takes one stereo pair per beat, the m_ stream returns one
//   filtered pair per beat. The APB-style port holds the mode, two pole
//   coefficients and five gains; write it only while the block is idle.
//   Both channels run side by side in their own lanes under one sequencer.
//   Every multiply is shift-and-add over one multiplier bit per cycle, with
//   M = max(COEF_BITS, 16) + 1 multiplier bits. An item runs a low pole
//   update (all modes but pass), a high pole update (mid boost and three-band
//   EQ only), then the base value and the gain products: one for pan and the
//   boost modes, three for three-band EQ and none for pass, low- and
//   high-pass. The result beat turns valid in the same cycle as the input
//   side turns ready again. A finished pair sits in an output register;
//   when the receiver stalls, the sequencer still accepts the next pair and
//   waits only at the point where it must hand over its own result.
//   Reset loads the register defaults and clears the four accumulators.
// ---------------------------------------------------------------------------
module stereo_one_pole_equalizer #(
    parameter int SAMPLE_BITS = sope_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_BITS    = sope_pkg::ACC_BITS_DEF,
    parameter int COEF_BITS   = sope_pkg::COEF_BITS_DEF,
    localparam int TDATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [TDATA_BITS-1:0]              s_tdata,   // left_sample, right_sample
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [TDATA_BITS-1:0]              m_tdata,   // left_result, right_result
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sope_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [sope_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [sope_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import sope_pkg::*;

    localparam int LANES     = 2;
    localparam int DIFF_BITS = ACC_BITS + 1;
    localparam int MUL_BITS  = ((COEF_BITS > GAIN_BITS) ? COEF_BITS : GAIN_BITS) + 1;
    localparam int PROD_BITS = DIFF_BITS + MUL_BITS + 2;
    localparam int CNT_BITS  = $clog2(MUL_BITS);
    localparam int ALIGN     = ACC_BITS - SAMPLE_BITS;
    localparam int OUT_SHIFT = GAIN_FRAC + ALIGN;
    localparam int TOP_BITS  = PROD_BITS - OUT_SHIFT - SAMPLE_BITS + 1;

    localparam logic [COEF_BITS-1:0] LOW_POLE_RST =
        COEF_BITS'((64'(COEF_LOW_POLE_RESET) << COEF_BITS) >> RESET_COEF_BITS);
    localparam logic [COEF_BITS-1:0] HIGH_POLE_RST =
        COEF_BITS'((64'(COEF_HIGH_POLE_RST) << COEF_BITS) >> RESET_COEF_BITS);
    localparam logic signed [PROD_BITS-1:0] POLE_ROUND = PROD_BITS'(1) << (COEF_BITS - 1);
    localparam logic signed [PROD_BITS-1:0] OUT_ROUND  = PROD_BITS'(1) << (OUT_SHIFT - 1);
    localparam logic signed [MUL_BITS-1:0]  GAIN_ONE   = MUL_BITS'(1) << GAIN_FRAC;
    localparam logic [CNT_BITS-1:0]         BIT_LAST   = CNT_BITS'(MUL_BITS - 1);

    // Configuration registers
    mode_t                  mode_reg;
    logic [COEF_BITS-1:0]   coef_low_reg;
    logic [COEF_BITS-1:0]   coef_high_reg;
    logic [GAIN_BITS-1:0]   gain_bass_reg;
    logic [GAIN_BITS-1:0]   gain_middle_reg;
    logic [GAIN_BITS-1:0]   gain_treble_reg;
    logic [GAIN_BITS-1:0]   pan_left_reg;
    logic [GAIN_BITS-1:0]   pan_right_reg;
    logic                   cfg_write;
    cfg_idx_t               cfg_idx;

    // Sequencer
    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_BITS-1:0]    bit_cnt_reg;
    logic [1:0]             term_idx_reg;
    logic                   bit_last;
    logic                   out_free;
    logic [1:0]             n_terms;
    term_t                  tsel;
    opd_t                   bsel;

    // Sequencer controls
    logic                   x_load;
    logic                   low_load;
    logic                   high_load;
    logic                   mul_run;
    logic                   low_upd;
    logic                   high_upd;
    logic                   base_load;
    logic                   term_load;
    logic                   out_load;

    // Lane datapath
    logic signed [SAMPLE_BITS-1:0] in_sample [LANES];
    logic signed [ACC_BITS-1:0]    x_reg     [LANES];
    logic signed [ACC_BITS-1:0]    low_reg   [LANES];
    logic signed [ACC_BITS-1:0]    high_reg  [LANES];
    logic signed [PROD_BITS-1:0]   prod_reg  [LANES];
    logic signed [PROD_BITS-1:0]   mcand_reg [LANES];
    logic signed [MUL_BITS-1:0]    mplier_reg[LANES];
    logic signed [DIFF_BITS-1:0]   dxl       [LANES];
    logic signed [DIFF_BITS-1:0]   dxh       [LANES];
    logic signed [DIFF_BITS-1:0]   base_val  [LANES];
    logic signed [DIFF_BITS-1:0]   term_val  [LANES];
    logic signed [MUL_BITS-1:0]    gain_val  [LANES];
    logic [SAMPLE_BITS-1:0]        sat_val   [LANES];
    logic [SAMPLE_BITS-1:0]        res_reg   [LANES];
    logic                          m_tvalid_reg;

    // Configuration write decode and read-back.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = cfg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_EQ;
            coef_low_reg    <= LOW_POLE_RST;
            coef_high_reg   <= HIGH_POLE_RST;
            gain_bass_reg   <= GAIN_RESET;
            gain_middle_reg <= GAIN_RESET;
            gain_treble_reg <= GAIN_RESET;
            pan_left_reg    <= PAN_RESET;
            pan_right_reg   <= PAN_RESET;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_FILTER_MODE: mode_reg        <= mode_t'(pwdata[MODE_BITS-1:0]);
                REG_COEF_LOW:    coef_low_reg    <= pwdata[COEF_BITS-1:0];
                REG_COEF_HIGH:   coef_high_reg   <= pwdata[COEF_BITS-1:0];
                REG_GAIN_BASS:   gain_bass_reg   <= pwdata[GAIN_BITS-1:0];
                REG_GAIN_MIDDLE: gain_middle_reg <= pwdata[GAIN_BITS-1:0];
                REG_GAIN_TREBLE: gain_treble_reg <= pwdata[GAIN_BITS-1:0];
                REG_PAN_LEFT:    pan_left_reg    <= pwdata[GAIN_BITS-1:0];
                REG_PAN_RIGHT:   pan_right_reg   <= pwdata[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FILTER_MODE: prdata = CFG_DATA_BITS'(mode_reg);
            REG_COEF_LOW:    prdata = CFG_DATA_BITS'(coef_low_reg);
            REG_COEF_HIGH:   prdata = CFG_DATA_BITS'(coef_high_reg);
            REG_GAIN_BASS:   prdata = CFG_DATA_BITS'(gain_bass_reg);
            REG_GAIN_MIDDLE: prdata = CFG_DATA_BITS'(gain_middle_reg);
            REG_GAIN_TREBLE: prdata = CFG_DATA_BITS'(gain_treble_reg);
            REG_PAN_LEFT:    prdata = CFG_DATA_BITS'(pan_left_reg);
            REG_PAN_RIGHT:   prdata = CFG_DATA_BITS'(pan_right_reg);
            default:         prdata = '0;
        endcase
    end

    // Mode decode shared by both lanes.
    assign n_terms  = term_count(mode_reg);
    assign tsel     = term_sel(mode_reg, term_idx_reg);
    assign bsel     = base_sel(mode_reg);
    assign bit_last = (bit_cnt_reg == BIT_LAST);
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: pole updates first, then the base value and gain products.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (mode_reg == MODE_PASS) ? ST_BASE : ST_LOW_PREP;
                end
            end
            ST_LOW_PREP:  state_next = ST_LOW_MUL;
            ST_LOW_MUL: begin
                if (bit_last) begin
                    state_next = ST_LOW_UPD;
                end
            end
            ST_LOW_UPD: begin
                if ((mode_reg == MODE_MID) || (mode_reg == MODE_EQ)) begin
                    state_next = ST_HIGH_PREP;
                end else begin
                    state_next = ST_BASE;
                end
            end
            ST_HIGH_PREP: state_next = ST_HIGH_MUL;
            ST_HIGH_MUL: begin
                if (bit_last) begin
                    state_next = ST_HIGH_UPD;
                end
            end
            ST_HIGH_UPD:  state_next = ST_BASE;
            ST_BASE:      state_next = (n_terms != 2'd0) ? ST_TERM_PREP : ST_RESULT;
            ST_TERM_PREP: state_next = ST_TERM_MUL;
            ST_TERM_MUL: begin
                if (bit_last) begin
                    state_next = (term_idx_reg + 2'd1 == n_terms) ? ST_RESULT : ST_TERM_PREP;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        x_load    = 1'b0;
        low_load  = 1'b0;
        high_load = 1'b0;
        mul_run   = 1'b0;
        low_upd   = 1'b0;
        high_upd  = 1'b0;
        base_load = 1'b0;
        term_load = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:      x_load    = s_tvalid;
            ST_LOW_PREP:  low_load  = 1'b1;
            ST_HIGH_PREP: high_load = 1'b1;
            ST_LOW_MUL, ST_HIGH_MUL, ST_TERM_MUL: mul_run = 1'b1;
            ST_LOW_UPD:   low_upd   = 1'b1;
            ST_HIGH_UPD:  high_upd  = 1'b1;
            ST_BASE:      base_load = 1'b1;
            ST_TERM_PREP: term_load = 1'b1;
            ST_RESULT:    out_load  = out_free;
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Bit and term counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg  <= '0;
            term_idx_reg <= '0;
        end else begin
            if (low_load || high_load || term_load) begin
                bit_cnt_reg <= '0;
            end else if (mul_run) begin
                bit_cnt_reg <= bit_cnt_reg + CNT_BITS'(1);
            end
            if (base_load) begin
                term_idx_reg <= '0;
            end else if (mul_run && bit_last && (state_reg == ST_TERM_MUL)) begin
                term_idx_reg <= term_idx_reg + 2'd1;
            end
        end
    end

    // Operand and multiplier selection in each lane.
    assign in_sample[0] = s_tdata[SAMPLE_BITS-1:0];
    assign in_sample[1] = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            dxl[i] = DIFF_BITS'(x_reg[i]) - DIFF_BITS'(low_reg[i]);
            dxh[i] = DIFF_BITS'(x_reg[i]) - DIFF_BITS'(high_reg[i]);

            case (bsel)
                OPD_X:     base_val[i] = DIFF_BITS'(x_reg[i]);
                OPD_LOW:   base_val[i] = DIFF_BITS'(low_reg[i]);
                OPD_X_LOW: base_val[i] = dxl[i];
                default:   base_val[i] = '0;
            endcase

            case (tsel.opd)
                OPD_LOW:      term_val[i] = DIFF_BITS'(low_reg[i]);
                OPD_X_LOW:    term_val[i] = dxl[i];
                OPD_HIGH_LOW: term_val[i] = DIFF_BITS'(high_reg[i]) - DIFF_BITS'(low_reg[i]);
                OPD_X_HIGH:   term_val[i] = dxh[i];
                default:      term_val[i] = '0;
            endcase

            case (tsel.gsel)
                GSEL_PAN: begin
                    gain_val[i] = (i == 0) ? MUL_BITS'(pan_left_reg) : MUL_BITS'(pan_right_reg);
                end
                GSEL_BASS:      gain_val[i] = MUL_BITS'(gain_bass_reg);
                GSEL_MIDDLE:    gain_val[i] = MUL_BITS'(gain_middle_reg);
                GSEL_TREBLE:    gain_val[i] = MUL_BITS'(gain_treble_reg);
                GSEL_BASS_M1:   gain_val[i] = MUL_BITS'(gain_bass_reg) - GAIN_ONE;
                GSEL_MIDDLE_M1: gain_val[i] = MUL_BITS'(gain_middle_reg) - GAIN_ONE;
                default:        gain_val[i] = MUL_BITS'(gain_treble_reg) - GAIN_ONE;
            endcase
        end
    end

    // Output rounding is preloaded, so only the shift and clamp remain here.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            logic [TOP_BITS-1:0] top;
            top = prod_reg[i][PROD_BITS-1:OUT_SHIFT+SAMPLE_BITS-1];
            if ((&top) || !(|top)) begin
                sat_val[i] = prod_reg[i][OUT_SHIFT +: SAMPLE_BITS];
            end else if (top[TOP_BITS-1]) begin
                sat_val[i] = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end else begin
                sat_val[i] = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            end
        end
    end

    // Lane accumulators: cleared by reset, updated after each pole multiply.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < LANES; i++) begin
            if (!aresetn) begin
                low_reg[i]  <= '0;
                high_reg[i] <= '0;
            end else begin
                if (low_upd) begin
                    low_reg[i] <= low_reg[i] + prod_reg[i][COEF_BITS +: ACC_BITS];
                end
                if (high_upd) begin
                    high_reg[i] <= high_reg[i] + prod_reg[i][COEF_BITS +: ACC_BITS];
                end
            end
        end
    end

    // Shift-and-add multiplier, one multiplier bit per cycle; the top bit
    // carries negative weight.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < LANES; i++) begin
            if (x_load) begin
                x_reg[i] <= ACC_BITS'(in_sample[i]) <<< ALIGN;
            end
            if (low_load) begin
                prod_reg[i]   <= POLE_ROUND;
                mcand_reg[i]  <= PROD_BITS'(dxl[i]);
                mplier_reg[i] <= MUL_BITS'(coef_low_reg);
            end else if (high_load) begin
                prod_reg[i]   <= POLE_ROUND;
                mcand_reg[i]  <= PROD_BITS'(dxh[i]);
                mplier_reg[i] <= MUL_BITS'(coef_high_reg);
            end else if (base_load) begin
                prod_reg[i] <= (PROD_BITS'(base_val[i]) <<< GAIN_FRAC) + OUT_ROUND;
            end else if (term_load) begin
                mcand_reg[i]  <= PROD_BITS'(term_val[i]);
                mplier_reg[i] <= gain_val[i];
            end else if (mul_run) begin
                if (mplier_reg[i][0]) begin
                    prod_reg[i] <= bit_last ? prod_reg[i] - mcand_reg[i]
                                            : prod_reg[i] + mcand_reg[i];
                end
                mcand_reg[i]  <= mcand_reg[i] <<< 1;
                mplier_reg[i] <= mplier_reg[i] >>> 1;
            end
        end
    end

    // Output register: holds the finished pair until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_reg[0] <= sat_val[0];
            res_reg[1] <= sat_val[1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_BITS'({res_reg[1], res_reg[0]});

    // Checks on the sequencer.
    `include "stereo_one_pole_equalizer_assert.svh"

    `SOPE_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready, "sequencer did not leave idle after accepting a beat")
    `SOPE_ASSERT_IMPL(a_term_range, aclk, aresetn, state_reg == ST_TERM_MUL, term_idx_reg < n_terms, "gain product index beyond the mode's term count")
    `SOPE_ASSERT_IMPL(a_bit_range, aclk, aresetn, mul_run, bit_cnt_reg < CNT_BITS'(MUL_BITS), "multiplier bit counter overran the multiplier width")
    `SOPE_ASSERT_NEXT(a_result_out, aclk, aresetn, out_load, m_tvalid, "finished result was not presented on the output")

endmodule
